// ----- rtl/spb_pkg.sv -----
`default_nettype none

package spb_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 20;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned PH_W  =
      ((IDX_W + FRAC_BITS > RATE_W) ? (IDX_W + FRAC_BITS) : RATE_W) + 1;
  localparam int unsigned ACC_W = SAMPLE_W + FRAC_BITS + 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_EMPTY   = 2'd1,
    CMD_APPEND  = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_RESTART = 4'b0001,
    OP_EMPTY   = 4'b0010,
    OP_APPEND  = 4'b0100,
    OP_READ    = 4'b1000
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [RATE_W-1:0]          rate;
  } spb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       finished;
  } spb_out_t;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [RATE_W-1:0]          rate;
  } spb_qitem_t;

endpackage

`default_nettype wire

// ----- rtl/spb_ram.sv -----
`default_nettype none

module spb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/spb_front.sv -----
`default_nettype none

module spb_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spb_pkg::spb_in_t    in_word_i,
  output logic                     q_valid_o,
  output spb_pkg::spb_qitem_t      q_item_o,
  input  wire logic                q_pop_i
);

  spb_pkg::spb_qitem_t               mem_q [spb_pkg::QUEUE_DEPTH];
  spb_pkg::spb_qitem_t               item;
  logic [spb_pkg::QPTR_W-1:0]        wptr_q, wptr_d;
  logic [spb_pkg::QPTR_W-1:0]        rptr_q, rptr_d;
  logic [spb_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                              push;

  // classify
  always_comb begin
    item.sample = in_word_i.sample_in;
    item.rate   = in_word_i.rate;
    unique case (in_word_i.cmd)
      spb_pkg::CMD_RESTART: item.op = spb_pkg::OP_RESTART;
      spb_pkg::CMD_EMPTY:   item.op = spb_pkg::OP_EMPTY;
      spb_pkg::CMD_APPEND:  item.op = spb_pkg::OP_APPEND;
      spb_pkg::CMD_READ:    item.op = spb_pkg::OP_READ;
      default:              item.op = spb_pkg::OP_READ;
    endcase
  end

  assign in_stall_o = (cnt_q == spb_pkg::QCNT_W'(spb_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == spb_pkg::QPTR_W'(spb_pkg::QUEUE_DEPTH - 1)) ? '0
             : wptr_q + spb_pkg::QPTR_W'(1);
    end
    if (q_pop_i) begin
      rptr_d = (rptr_q == spb_pkg::QPTR_W'(spb_pkg::QUEUE_DEPTH - 1)) ? '0
             : rptr_q + spb_pkg::QPTR_W'(1);
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + spb_pkg::QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - spb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spb_back.sv -----
`default_nettype none

module spb_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire spb_pkg::spb_qitem_t q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output spb_pkg::spb_out_t        out_word_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH1 = 4'b0010,
    ST_DIFF   = 4'b0100,
    ST_MAC    = 4'b1000
  } state_e;

  state_e                                state_q, state_d;
  logic [spb_pkg::LEN_W-1:0]             length_q, length_d;
  logic [spb_pkg::PH_W-1:0]              playhead_q, playhead_d;
  logic [spb_pkg::RATE_W-1:0]            rate_q, rate_d;
  logic signed [spb_pkg::SAMPLE_W-1:0]   s0_q, s0_d;
  logic signed [spb_pkg::SAMPLE_W:0]     diff_q, diff_d;
  logic                                  out_valid_q, out_valid_d;
  spb_pkg::spb_out_t                     out_word_q, out_word_d;

  logic [spb_pkg::IDX_W-1:0]             idx0;
  logic [spb_pkg::FRAC_BITS-1:0]         frac;
  logic signed [spb_pkg::FRAC_BITS:0]    frac_s;
  logic [spb_pkg::LEN_W-1:0]             last;
  logic [spb_pkg::PH_W-1:0]              end_pos;
  logic                                  at_end;
  logic                                  out_free;
  logic                                  not_full;
  logic                                  ram_we;
  logic [spb_pkg::IDX_W-1:0]             ram_raddr;
  logic [spb_pkg::SAMPLE_W-1:0]          ram_rdata;
  logic signed [spb_pkg::ACC_W-1:0]      base;
  logic signed [spb_pkg::ACC_W-1:0]      prod;
  logic signed [spb_pkg::ACC_W-1:0]      acc;

  assign idx0     = playhead_q[spb_pkg::FRAC_BITS +: spb_pkg::IDX_W];
  assign frac     = playhead_q[spb_pkg::FRAC_BITS-1:0];
  assign frac_s   = signed'({1'b0, frac});
  assign last     = length_q - spb_pkg::LEN_W'(1);
  assign end_pos  = spb_pkg::PH_W'(last) << spb_pkg::FRAC_BITS;
  assign at_end   = (length_q < spb_pkg::LEN_W'(2)) || (playhead_q >= end_pos);
  assign out_free = !out_valid_q || !out_stall_i;
  assign not_full = (length_q < spb_pkg::LEN_W'(spb_pkg::STORE_DEPTH));

  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i &&
                    ((q_item_i.op != spb_pkg::OP_READ) || out_free);
  assign ram_we   = q_pop_o && (q_item_i.op == spb_pkg::OP_APPEND) && not_full;
  assign ram_raddr = (state_q == ST_FETCH1) ? idx0 + spb_pkg::IDX_W'(1) : idx0;

  // round half up: the half lsb sits in the low bits of the shifted s0
  assign base = {{2{s0_q[spb_pkg::SAMPLE_W-1]}}, s0_q, 1'b1,
                 {(spb_pkg::FRAC_BITS-1){1'b0}}};
  assign prod = spb_pkg::ACC_W'(diff_q) * spb_pkg::ACC_W'(frac_s);
  assign acc  = base + prod;

  spb_ram #(
    .WIDTH (spb_pkg::SAMPLE_W),
    .DEPTH (spb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (length_q[spb_pkg::IDX_W-1:0]),
    .wdata_i (q_item_i.sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    playhead_d  = playhead_q;
    rate_d      = rate_q;
    s0_d        = s0_q;
    diff_d      = diff_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          unique case (q_item_i.op)
            spb_pkg::OP_RESTART: begin
              playhead_d = '0;
            end
            spb_pkg::OP_EMPTY: begin
              length_d = '0;
            end
            spb_pkg::OP_APPEND: begin
              if (not_full) begin
                length_d = length_q + spb_pkg::LEN_W'(1);
              end
            end
            spb_pkg::OP_READ: begin
              rate_d = q_item_i.rate;
              if (at_end) begin
                out_valid_d           = 1'b1;
                out_word_d.sample_out = '0;
                out_word_d.finished   = 1'b1;
              end else begin
                state_d = ST_FETCH1;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FETCH1: begin
        s0_d    = signed'(ram_rdata);
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        diff_d  = signed'({ram_rdata[spb_pkg::SAMPLE_W-1], ram_rdata})
                - signed'({s0_q[spb_pkg::SAMPLE_W-1], s0_q});
        state_d = ST_MAC;
      end
      ST_MAC: begin
        out_valid_d           = 1'b1;
        out_word_d.sample_out = acc[spb_pkg::FRAC_BITS +: spb_pkg::SAMPLE_W];
        out_word_d.finished   = 1'b0;
        playhead_d            = playhead_q + spb_pkg::PH_W'(rate_q);
        state_d               = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rate_q     <= rate_d;
    s0_q       <= s0_d;
    diff_q     <= diff_d;
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      length_q    <= '0;
      playhead_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      playhead_q  <= playhead_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ----- rtl/sample_playback_interpolator_core.sv -----
// Mono sample player with a fractional playhead and linear interpolation. Words
// enter a two-word queue, so the input takes a new word while a result waits
// in the output register. Restart, empty and append commands are executed in
// the idle state of the execution unit; a read steps through two fetches of
// adjacent entries from the single read port of the sample store, a difference
// step and a multiply-add, unless the playhead sits at the end, when the result
// is zero with finished set. The store powers up undefined and needs no
// clearing: only appended entries are ever read.
`default_nettype none

module sample_playback_interpolator_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire spb_pkg::spb_in_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output spb_pkg::spb_out_t     out_word_o
);

  logic                q_valid;
  logic                q_pop;
  spb_pkg::spb_qitem_t q_item;

  spb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  spb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  a_finished_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.finished |-> out_word_o.sample_out == '0)
    else $error("finished word with nonzero sample");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_full_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("input stalled with empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted word missing from queue");
`endif

endmodule

`default_nettype wire

// ----- bench/sample_playback_interpolator_core_tb.sv -----
`timescale 1ns / 1ps

module sample_playback_interpolator_core_tb;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint ONE = longint'(1) << spb_pkg::FRAC_BITS;

  typedef struct packed {
    spb_pkg::cmd_e                       cmd;
    logic signed [spb_pkg::SAMPLE_W-1:0] smp;
    logic [spb_pkg::RATE_W-1:0]          rate;
    logic                                known;
    logic signed [spb_pkg::SAMPLE_W-1:0] exp_smp;
    logic                                exp_fin;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 23;
  localparam plan_row_t DIR_PLAN [PLAN_LEN] = '{
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_APPEND,  16'sh7FFF, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'hFFFFF, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_APPEND,  16'sh8000, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh7FFF, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h08000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'hFFFFF, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_APPEND,  16'sh0001, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_RESTART, 16'sh0000, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h0C000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h04000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_EMPTY,   16'sh0000, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_APPEND,  16'sh1234, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_APPEND,  16'shFFFF, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b1, 16'sh0000, 1'b1},
    '{spb_pkg::CMD_RESTART, 16'sh5A5A, 20'hA5A5A, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00001, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h00000, 1'b0, 16'sh0000, 1'b0},
    '{spb_pkg::CMD_READ,    16'sh0000, 20'h10000, 1'b0, 16'sh0000, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  spb_pkg::spb_in_t  in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  spb_pkg::spb_out_t out_word;

  logic signed [spb_pkg::SAMPLE_W-1:0] pcm_mem [spb_pkg::STORE_DEPTH];
  logic [spb_pkg::LEN_W-1:0]           pcm_len;
  logic [spb_pkg::PH_W-1:0]            head_pos;
  spb_pkg::spb_out_t                   pending_out [$];

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int quiet_cnt = 0;
  int phase_words = 0;

  sample_playback_interpolator_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #2 clk = ~clk;

  task automatic play_word(input spb_pkg::spb_in_t w, output bit has_res,
                           output spb_pkg::spb_out_t res);
    longint s0;
    longint s1;
    longint frac;
    longint acc;
    logic [spb_pkg::IDX_W-1:0] idx;
    has_res = 1'b0;
    res = '0;
    case (spb_pkg::cmd_e'(w.cmd))
      spb_pkg::CMD_RESTART: head_pos = '0;
      spb_pkg::CMD_EMPTY:   pcm_len = '0;
      spb_pkg::CMD_APPEND: begin
        if (pcm_len < spb_pkg::STORE_DEPTH) begin
          pcm_mem[pcm_len[spb_pkg::IDX_W-1:0]] = w.sample_in;
          pcm_len = pcm_len + spb_pkg::LEN_W'(1);
        end
      end
      default: begin
        has_res = 1'b1;
        if (pcm_len < 2 || longint'(head_pos) >= (longint'(pcm_len) - 1) * ONE) begin
          res.sample_out = '0;
          res.finished = 1'b1;
        end else begin
          idx = spb_pkg::IDX_W'(head_pos >> spb_pkg::FRAC_BITS);
          frac = longint'(head_pos[spb_pkg::FRAC_BITS-1:0]);
          s0 = pcm_mem[idx];
          s1 = pcm_mem[idx + spb_pkg::IDX_W'(1)];
          acc = s0 * (ONE - frac) + s1 * frac + (ONE >>> 1);
          acc = acc >>> spb_pkg::FRAC_BITS;
          res.sample_out = acc[spb_pkg::SAMPLE_W-1:0];
          res.finished = 1'b0;
          head_pos = head_pos + spb_pkg::PH_W'(w.rate);
        end
      end
    endcase
  endtask

  task automatic send_word(input spb_pkg::spb_in_t w, input bit known,
                           input spb_pkg::spb_out_t typed);
    bit                has_res;
    spb_pkg::spb_out_t res;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    play_word(w, has_res, res);
    if (has_res) pending_out.push_back(known ? typed : res);
    phase_words++;
    @(negedge clk);
  endtask

  task automatic push_word(input spb_pkg::cmd_e cmd,
                           input logic [spb_pkg::SAMPLE_W-1:0] smp,
                           input logic [spb_pkg::RATE_W-1:0] rate);
    spb_pkg::spb_in_t w;
    w.cmd = cmd;
    w.sample_in = smp;
    w.rate = rate;
    send_word(w, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_out.size() != 0);
  endtask

  function automatic logic [spb_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return spb_pkg::SAMPLE_W'($urandom_range(255)) - 16'd128;
      default: return spb_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [spb_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(9))
      0:       return spb_pkg::RATE_W'($urandom);
      1:       return spb_pkg::RATE_W'($urandom_range(15)) << spb_pkg::FRAC_BITS;
      2:       return spb_pkg::RATE_W'($urandom_range(255));
      3:       return 20'hFFFFF;
      default: return spb_pkg::RATE_W'($urandom_range(32'h20000));
    endcase
  endfunction

  task automatic random_phase(input int target);
    int n_app;
    int n_rd;
    logic [spb_pkg::RATE_W-1:0] rate;
    phase_words = 0;
    while (phase_words < target) begin
      if ($urandom_range(9) == 0) begin
        push_word(spb_pkg::cmd_e'($urandom_range(3)), spb_pkg::SAMPLE_W'($urandom),
                  spb_pkg::RATE_W'($urandom));
      end else begin
        if ($urandom_range(2) == 0) push_word(spb_pkg::CMD_EMPTY, pick_sample(), pick_rate());
        n_app = $urandom_range(1, 24);
        repeat (n_app) push_word(spb_pkg::CMD_APPEND, pick_sample(), pick_rate());
        if ($urandom_range(3) != 0) push_word(spb_pkg::CMD_RESTART, pick_sample(), pick_rate());
        n_rd = $urandom_range(1, 40);
        rate = pick_rate();
        repeat (n_rd) begin
          if ($urandom_range(7) == 0) rate = pick_rate();
          if ($urandom_range(29) == 0) begin
            push_word(spb_pkg::CMD_RESTART, pick_sample(), pick_rate());
          end
          push_word(spb_pkg::CMD_READ, pick_sample(), rate);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle);
    if (hold_left != 0) hold_left--;
  end

  always @(posedge clk) begin
    spb_pkg::spb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        $error("unexpected word: sample_out %0d, finished %0d",
               out_word.sample_out, out_word.finished);
        err_cnt++;
      end else begin
        want = pending_out.pop_front();
        if (out_word.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_word.sample_out);
          err_cnt++;
        end
        if (out_word.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, out_word.finished);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
    end
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    spb_pkg::spb_in_t  w;
    spb_pkg::spb_out_t typed;
    pcm_len = '0;
    head_pos = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    snd_idle = 6;
    rcv_idle = 76;
    for (int i = 0; i < PLAN_LEN; i++) begin
      w.cmd = DIR_PLAN[i].cmd;
      w.sample_in = DIR_PLAN[i].smp;
      w.rate = DIR_PLAN[i].rate;
      typed.sample_out = DIR_PLAN[i].exp_smp;
      typed.finished = DIR_PLAN[i].exp_fin;
      send_word(w, DIR_PLAN[i].known, typed);
    end
    random_phase(280);
    wait_idle();

    snd_idle = 76;
    rcv_idle = 6;
    random_phase(280);
    wait_idle();

    snd_idle = 0;
    rcv_idle = 0;
    hold_seq++;
    random_phase(280);
    wait_idle();
    repeat (20) @(negedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sample_playback_interpolator_core.f -----
rtl/spb_pkg.sv
rtl/spb_ram.sv
rtl/spb_front.sv
rtl/spb_back.sv
rtl/sample_playback_interpolator_core.sv
bench/sample_playback_interpolator_core_tb.sv
